### hw/rtl/ppmd_pkg.sv
`timescale 1ns / 1ps

package ppmd_pkg;

  localparam int unsigned DistSqW = 38;
  localparam int unsigned DistW   = 19;

  localparam logic [DistSqW-1:0] DistSqMax = '1;

  typedef struct packed {
    logic load;
    logic step;
  } unit_ctrl_t;

endpackage

### hw/rtl/ppmd_mac.sv
`timescale 1ns / 1ps

module ppmd_mac #(
  parameter  int unsigned COORD_WIDTH = 18,
  localparam int unsigned AccW        = 2 * COORD_WIDTH + 2
) (
  input  logic                       clk_i,
  input  ppmd_pkg::unit_ctrl_t       ctrl_i,
  input  logic [9*COORD_WIDTH-1:0]   coords_i,
  output logic [AccW-1:0]            x2_o,
  output logic [AccW-1:0]            r2_o,
  output logic [AccW-1:0]            pos_o,
  output logic [AccW-1:0]            neg_o
);
  import ppmd_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned PW = 2 * CW;

  logic signed [CW:0] xd [3];
  logic signed [CW:0] rd [3];
  logic        [CW:0] nx [3];
  logic        [CW:0] nr [3];
  logic [CW-1:0] ux [3];
  logic [CW-1:0] ur [3];

  logic [CW-1:0] mx_q [3];
  logic [CW-1:0] mx_d [3];
  logic [CW-1:0] mr_q [3];
  logic [CW-1:0] mr_d [3];
  logic [PW-1:0] sx_q [3];
  logic [PW-1:0] sx_d [3];
  logic [PW-1:0] sr_q [3];
  logic [PW-1:0] sr_d [3];
  logic [2:0]    opp_q, opp_d;
  logic [AccW-1:0] x2_q, x2_d, r2_q, r2_d, pos_q, pos_d, neg_q, neg_d;

  // differences and magnitudes per axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xd[k] = $signed({coords_i[(3+k)*CW+CW-1], coords_i[(3+k)*CW +: CW]})
            - $signed({coords_i[k*CW+CW-1], coords_i[k*CW +: CW]});
      rd[k] = $signed({coords_i[(6+k)*CW+CW-1], coords_i[(6+k)*CW +: CW]})
            - $signed({coords_i[(3+k)*CW+CW-1], coords_i[(3+k)*CW +: CW]});
      nx[k] = -xd[k];
      nr[k] = -rd[k];
      ux[k] = xd[k][CW] ? nx[k][CW-1:0] : xd[k][CW-1:0];
      ur[k] = rd[k][CW] ? nr[k][CW-1:0] : rd[k][CW-1:0];
    end
  end

  // one multiplier bit per cycle while step is set, three axes side by side
  always_comb begin
    x2_d  = x2_q;
    r2_d  = r2_q;
    pos_d = pos_q;
    neg_d = neg_q;
    opp_d = opp_q;
    for (int k = 0; k < 3; k++) begin
      mx_d[k] = mx_q[k];
      mr_d[k] = mr_q[k];
      sx_d[k] = sx_q[k];
      sr_d[k] = sr_q[k];
    end
    if (ctrl_i.load) begin
      x2_d  = '0;
      r2_d  = '0;
      pos_d = '0;
      neg_d = '0;
      for (int k = 0; k < 3; k++) begin
        mx_d[k]  = ux[k];
        mr_d[k]  = ur[k];
        sx_d[k]  = PW'(ux[k]);
        sr_d[k]  = PW'(ur[k]);
        opp_d[k] = xd[k][CW] ^ rd[k][CW];
      end
    end else if (ctrl_i.step) begin
      for (int k = 0; k < 3; k++) begin
        x2_d = x2_d + AccW'(mx_q[k][0] ? sx_q[k] : '0);
        r2_d = r2_d + AccW'(mr_q[k][0] ? sr_q[k] : '0);
        if (opp_q[k]) begin
          neg_d = neg_d + AccW'(mx_q[k][0] ? sr_q[k] : '0);
        end else begin
          pos_d = pos_d + AccW'(mx_q[k][0] ? sr_q[k] : '0);
        end
        mx_d[k] = mx_q[k] >> 1;
        mr_d[k] = mr_q[k] >> 1;
        sx_d[k] = sx_q[k] << 1;
        sr_d[k] = sr_q[k] << 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x2_q  <= x2_d;
    r2_q  <= r2_d;
    pos_q <= pos_d;
    neg_q <= neg_d;
    opp_q <= opp_d;
    for (int k = 0; k < 3; k++) begin
      mx_q[k] <= mx_d[k];
      mr_q[k] <= mr_d[k];
      sx_q[k] <= sx_d[k];
      sr_q[k] <= sr_d[k];
    end
  end

  assign x2_o  = x2_q;
  assign r2_o  = r2_q;
  assign pos_o = pos_q;
  assign neg_o = neg_q;

endmodule

### hw/rtl/ppmd_div.sv
`timescale 1ns / 1ps

module ppmd_div #(
  parameter int unsigned DW = 38
) (
  input  logic                 clk_i,
  input  ppmd_pkg::unit_ctrl_t ctrl_i,
  input  logic [DW-1:0]        a_i,
  input  logic [DW-1:0]        b_i,
  output logic [DW-1:0]        quot_o,
  output logic                 rem_nz_o
);
  import ppmd_pkg::*;

  localparam int unsigned RW = DW + 2;

  logic [DW-1:0] a_q, a_d, a_sh_q, a_sh_d, b_q, b_d, quot_q, quot_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] sum;
  logic [RW:0]   t1, t2;

  // a*a by horner over the bits of a, reduced modulo b as it grows
  always_comb begin
    sum = {rem_q[RW-2:0], 1'b0} + (a_sh_q[DW-1] ? RW'(a_q) : '0);
    t1  = {1'b0, sum} - (RW+1)'(b_q);
    t2  = {1'b0, sum} - (RW+1)'({b_q, 1'b0});
    a_d    = a_q;
    a_sh_d = a_sh_q;
    b_d    = b_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (ctrl_i.load) begin
      a_d    = a_i;
      a_sh_d = a_i;
      b_d    = b_i;
      quot_d = '0;
      rem_d  = '0;
    end else if (ctrl_i.step) begin
      a_sh_d = a_sh_q << 1;
      priority if (!t2[RW]) begin
        rem_d  = t2[RW-1:0];
        quot_d = {quot_q[DW-2:0], 1'b0} + DW'(2);
      end else if (!t1[RW]) begin
        rem_d  = t1[RW-1:0];
        quot_d = {quot_q[DW-2:0], 1'b1};
      end else begin
        rem_d  = sum;
        quot_d = {quot_q[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    a_sh_q <= a_sh_d;
    b_q    <= b_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign quot_o   = quot_q;
  assign rem_nz_o = |rem_q;

endmodule

### hw/rtl/ppmd_sqrt.sv
`timescale 1ns / 1ps

module ppmd_sqrt (
  input  logic                          clk_i,
  input  ppmd_pkg::unit_ctrl_t          ctrl_i,
  input  logic [ppmd_pkg::DistSqW-1:0]  val_i,
  output logic [ppmd_pkg::DistW-1:0]    root_o
);
  import ppmd_pkg::*;

  localparam int unsigned RemW = DistW + 3;

  logic [DistSqW-1:0] v_q, v_d;
  logic [RemW-1:0]    rem_q, rem_d, rem_n, trial;
  logic [DistW-1:0]   root_q, root_d;

  // two radicand bits in, one root bit out per cycle while step is set
  always_comb begin
    rem_n  = {rem_q[RemW-3:0], v_q[DistSqW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    v_d    = v_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (ctrl_i.load) begin
      v_d    = val_i;
      rem_d  = '0;
      root_d = '0;
    end else if (ctrl_i.step) begin
      v_d = v_q << 2;
      if (rem_n >= trial) begin
        rem_d  = rem_n - trial;
        root_d = {root_q[DistW-2:0], 1'b1};
      end else begin
        rem_d  = rem_n;
        root_d = {root_q[DistW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

### hw/rtl/point_polyline_min_distance.sv
// sequence: serial multiply, evaluate and case states from input transfer to the running minimum update
// projection inside the segment: the serial divider and a subtract state come in between, one quotient
//   bit a cycle; a last segment adds the 19 root digits and the result load
// throughput: one segment at a time, the next transfer is taken on return to idle
// reset: running minimum all ones, result register empty, no clearing pass
`timescale 1ns / 1ps

module point_polyline_min_distance #(
  parameter  int unsigned COORD_WIDTH = 18,
  localparam int unsigned InDataW     = ((9 * COORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutDataW    = ((ppmd_pkg::DistSqW + ppmd_pkg::DistW + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // query_x, query_y, query_z, seg_start_x, seg_start_y, seg_start_z,
  // seg_end_x, seg_end_y, seg_end_z
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                s_axis_tlast_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // min_dist_sq, min_dist
  output logic [OutDataW-1:0] m_axis_tdata_o
);
  import ppmd_pkg::*;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned AccW = 2 * CW + 2;
  localparam int unsigned VW   = AccW > DistSqW ? AccW : DistSqW;
  localparam int unsigned CntW = $clog2(AccW);
  localparam int unsigned ChkW = 2 * DistW + 2;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_EVAL = 4'd2;
  localparam logic [3:0] ST_CASE = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_SUB  = 4'd5;
  localparam logic [3:0] ST_MIN  = 4'd6;
  localparam logic [3:0] ST_SQRT = 4'd7;
  localparam logic [3:0] ST_PUSH = 4'd8;

  logic [3:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                last_q, last_d;
  logic [DistSqW-1:0]  min_q, min_d;
  logic                ovalid_q, ovalid_d;

  logic                skip_q, skip_d;
  logic [AccW-1:0]     a_q, a_d, d_q, d_d;
  logic [DistSqW-1:0]  sq_q, sq_d;
  logic [OutDataW-1:0] out_q, out_d;

  unit_ctrl_t          mac_ctrl, div_ctrl, sqrt_ctrl;
  logic [AccW-1:0]     x2, r2, pos, neg, quot;
  logic                rem_nz;
  logic [DistW-1:0]    root;

  logic [AccW:0]       end_val;
  logic [VW-1:0]       dz;
  logic [DistSqW-1:0]  dsat, new_min;

  ppmd_mac #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .coords_i(s_axis_tdata_i[9*CW-1:0]),
    .x2_o    (x2),
    .r2_o    (r2),
    .pos_o   (pos),
    .neg_o   (neg)
  );

  ppmd_div #(
    .DW(AccW)
  ) u_div (
    .clk_i   (clk_i),
    .ctrl_i  (div_ctrl),
    .a_i     (a_q),
    .b_i     (r2),
    .quot_o  (quot),
    .rem_nz_o(rem_nz)
  );

  ppmd_sqrt u_sqrt (
    .clk_i (clk_i),
    .ctrl_i(sqrt_ctrl),
    .val_i (new_min),
    .root_o(root)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = out_q;

  always_comb begin
    end_val = {1'b0, x2} + {1'b0, r2} - {a_q, 1'b0};
    dz      = VW'(d_q);
    dsat    = (dz > VW'(DistSqMax)) ? DistSqMax : dz[DistSqW-1:0];
    new_min = (dsat < min_q) ? dsat : min_q;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    min_d     = min_q;
    ovalid_d  = ovalid_q;
    skip_d    = skip_q;
    a_d       = a_q;
    d_d       = d_q;
    sq_d      = sq_q;
    out_d     = out_q;
    mac_ctrl  = '0;
    div_ctrl  = '0;
    sqrt_ctrl = '0;
    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (s_axis_tvalid_i) begin
          mac_ctrl.load = 1'b1;
          last_d        = s_axis_tlast_i;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        mac_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CntW'(CW - 1)) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        skip_d  = (r2 == '0) || (pos >= neg);
        a_d     = neg - pos;
        state_d = ST_CASE;
      end
      ST_CASE: begin
        priority if (skip_q) begin
          d_d     = x2;
          state_d = ST_MIN;
        end else if (a_q > r2) begin
          // past the end
          d_d     = end_val[AccW-1:0];
          state_d = ST_MIN;
        end else begin
          div_ctrl.load = 1'b1;
          cnt_d         = '0;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        div_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CntW'(AccW - 1)) begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        // rounded-up quotient, so the distance rounds down
        d_d     = x2 - quot - AccW'(rem_nz);
        state_d = ST_MIN;
      end
      ST_MIN: begin
        if (last_q) begin
          sq_d           = new_min;
          min_d          = DistSqMax;
          sqrt_ctrl.load = 1'b1;
          cnt_d          = '0;
          state_d        = ST_SQRT;
        end else begin
          min_d   = new_min;
          state_d = ST_IDLE;
        end
      end
      ST_SQRT: begin
        sqrt_ctrl.step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DistW - 1)) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!ovalid_q || m_axis_tready_i) begin
          out_d    = OutDataW'({root, sq_q});
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      last_q   <= 1'b0;
      min_q    <= DistSqMax;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
      min_q    <= min_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skip_q <= skip_d;
    a_q    <= a_d;
    d_q    <= d_d;
    sq_q   <= sq_d;
    out_q  <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIN && last_q) |=> (min_q == DistSqMax))
    else $error("running minimum not cleared after last segment");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |->
      ((ChkW'(root) * ChkW'(root) <= ChkW'(sq_q)) &&
       ((ChkW'(root) + 1'b1) * (ChkW'(root) + 1'b1) > ChkW'(sq_q))))
    else $error("square root out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CASE && !skip_q) |-> (a_q != '0))
    else $error("divider started with zero numerator");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_PUSH))
    else $error("result raised outside result load");

endmodule

### sim/tb_point_polyline_min_distance.sv
`timescale 1ns / 1ps

module tb_point_polyline_min_distance;
  import ppmd_pkg::*;

  localparam int unsigned CW         = 18;
  localparam int unsigned InDataW    = ((9 * CW + 7) / 8) * 8;
  localparam int unsigned OutDataW   = ((DistSqW + DistW + 7) / 8) * 8;
  localparam int          One        = 1 << 14;
  localparam int          CoordMax   = (1 << (CW - 1)) - 1;
  localparam int          CoordMin   = -(1 << (CW - 1));
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainWait  = 100;

  typedef struct packed {
    logic [CW-1:0] query_x;
    logic [CW-1:0] query_y;
    logic [CW-1:0] query_z;
    logic [CW-1:0] seg_start_x;
    logic [CW-1:0] seg_start_y;
    logic [CW-1:0] seg_start_z;
    logic [CW-1:0] seg_end_x;
    logic [CW-1:0] seg_end_y;
    logic [CW-1:0] seg_end_z;
    logic          last_segment;
  } segment_t;

  typedef struct {
    logic [DistSqW-1:0] min_dist_sq;
    logic [DistW-1:0]   min_dist;
  } polyline_result_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tlast_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  polyline_result_t   pending_minima[$];
  logic [DistSqW-1:0] nearest_sq = DistSqMax;
  int unsigned        mismatches = 0;
  int unsigned        segments_sent = 0;
  int unsigned        burst_left = 0;
  bit                 sender_steady = 1'b0;
  int unsigned        ready_run = 0;
  int unsigned        idle_cycles = 0;

  point_polyline_min_distance #(
    .COORD_WIDTH(CW)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [InDataW-1:0] pack_segment(input segment_t sg);
    logic [InDataW-1:0] v;
    v = '0;
    v[9*CW-1:0] = {sg.seg_end_z, sg.seg_end_y, sg.seg_end_x,
                   sg.seg_start_z, sg.seg_start_y, sg.seg_start_x,
                   sg.query_z, sg.query_y, sg.query_x};
    return v;
  endfunction

  // clamped squared distance from the query point to one segment, rounded down
  function automatic logic [DistSqW-1:0] segment_dist_sq(input segment_t sg);
    logic [CW-1:0] pt[3];
    logic [CW-1:0] st[3];
    logic [CW-1:0] en[3];
    longint        xd, rd, x2, r2, dot, dsq;
    logic [63:0]   a_u;
    logic [127:0]  num, den, quo;
    pt[0] = sg.query_x;     pt[1] = sg.query_y;     pt[2] = sg.query_z;
    st[0] = sg.seg_start_x; st[1] = sg.seg_start_y; st[2] = sg.seg_start_z;
    en[0] = sg.seg_end_x;   en[1] = sg.seg_end_y;   en[2] = sg.seg_end_z;
    x2 = 0;
    r2 = 0;
    dot = 0;
    for (int k = 0; k < 3; k++) begin
      xd = longint'($signed(st[k])) - longint'($signed(pt[k]));
      rd = longint'($signed(en[k])) - longint'($signed(st[k]));
      x2 += xd * xd;
      r2 += rd * rd;
      dot += xd * rd;
    end
    if (r2 == 0 || dot >= 0) begin
      dsq = x2;
    end else if (-dot > r2) begin
      dsq = x2 + r2 + 2 * dot;
    end else begin
      a_u = 64'(-dot);
      num = {64'd0, a_u} * {64'd0, a_u};
      den = {64'd0, 64'(r2)};
      quo = (num + den - 128'd1) / den;
      dsq = x2 - longint'(quo[63:0]);
    end
    if (dsq >= longint'({26'd0, DistSqMax})) return DistSqMax;
    return dsq[DistSqW-1:0];
  endfunction

  function automatic logic [DistW-1:0] floor_sqrt(input logic [DistSqW-1:0] v);
    logic [63:0] rem, root, bitv;
    rem = {26'd0, v};
    root = 64'd0;
    bitv = 64'd1 << 38;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[DistW-1:0];
  endfunction

  function automatic void fold_segment(input segment_t sg);
    logic [DistSqW-1:0] d;
    polyline_result_t   res;
    d = segment_dist_sq(sg);
    if (d < nearest_sq) nearest_sq = d;
    if (sg.last_segment) begin
      res.min_dist_sq = nearest_sq;
      res.min_dist = floor_sqrt(nearest_sq);
      pending_minima.push_back(res);
      nearest_sq = DistSqMax;
    end
  endfunction

  function automatic int clip_coord(input int v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  function automatic int rand_coord(input int span);
    return int'($urandom_range(0, 2 * span - 1)) - span;
  endfunction

  task automatic send_segment(input segment_t sg);
    if (!sender_steady && burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    s_axis_tdata_i <= pack_segment(sg);
    s_axis_tlast_i <= sg.last_segment;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    fold_segment(sg);
    segments_sent++;
    if (burst_left != 0) burst_left--;
    @(negedge clk_i);
  endtask

  task automatic send_coords(input int qx, input int qy, input int qz,
                             input int sx, input int sy, input int sz,
                             input int ex, input int ey, input int ez,
                             input bit last);
    segment_t sg;
    sg.query_x = CW'(qx);
    sg.query_y = CW'(qy);
    sg.query_z = CW'(qz);
    sg.seg_start_x = CW'(sx);
    sg.seg_start_y = CW'(sy);
    sg.seg_start_z = CW'(sz);
    sg.seg_end_x = CW'(ex);
    sg.seg_end_y = CW'(ey);
    sg.seg_end_z = CW'(ez);
    sg.last_segment = last;
    send_segment(sg);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending_minima.size() != 0);
  endtask

  // closed polyline around a random centre, one query point for all its segments
  task automatic send_polyline(input int unsigned n, input int span);
    int vx[16], vy[16], vz[16];
    int cx, cy, cz, px, py, pz, nx;
    cx = rand_coord(1 << (CW - 1));
    cy = rand_coord(1 << (CW - 1));
    cz = rand_coord(1 << (CW - 1));
    for (int j = 0; j < n; j++) begin
      if (j > 0 && $urandom_range(0, 7) == 0) begin
        vx[j] = vx[j-1];
        vy[j] = vy[j-1];
        vz[j] = vz[j-1];
      end else begin
        vx[j] = clip_coord(cx + rand_coord(span));
        vy[j] = clip_coord(cy + rand_coord(span));
        vz[j] = clip_coord(cz + rand_coord(span));
      end
    end
    px = clip_coord(cx + rand_coord(2 * span));
    py = clip_coord(cy + rand_coord(2 * span));
    pz = clip_coord(cz + rand_coord(2 * span));
    for (int j = 0; j < n; j++) begin
      nx = (j + 1) % n;
      send_coords(px, py, pz, vx[j], vy[j], vz[j], vx[nx], vy[nx], vz[nx], j == n - 1);
    end
  endtask

  task automatic test_directed();
    send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    send_coords(0, 0, 0, One, 0, 0, 2 * One, 0, 0, 1'b1);
    send_coords(0, 0, 0, One, 0, 0, One, One, 0, 1'b1);
    send_coords(3 * One, 0, 0, 0, 0, 0, One, 0, 0, 1'b1);
    send_coords(One / 2, One, 0, 0, 0, 0, One, 0, 0, 1'b1);
    send_coords(5, 7, 3, 0, 0, 0, 11, 13, 2, 1'b1);
    send_coords(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax,
                CoordMax, CoordMax, CoordMax, 1'b1);
    send_coords(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin,
                CoordMax, CoordMax, CoordMax, 1'b1);
    send_coords(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax,
                CoordMin, CoordMin, CoordMin, 1'b0);
    send_coords(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin,
                CoordMin, CoordMin, CoordMin, 1'b0);
    send_coords(0, 0, 0, CoordMin, CoordMax, CoordMin, CoordMax, CoordMin, CoordMax, 1'b1);
    send_coords(0, 0, 0, One, One, One, -One, One, One, 1'b0);
    send_coords(0, 0, 0, -One, One, One, -One, -One, One, 1'b0);
    send_coords(0, 0, 0, -One, -One, One, One, -One, One, 1'b0);
    send_coords(0, 0, 0, One, -One, One, One, One, One, 1'b1);
    send_coords(One, -One, One, -One, One, -One, One, -One, One, 1'b0);
    send_coords(One, -One, One, CoordMax, CoordMax, CoordMax, CoordMin, CoordMax, 0, 1'b1);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++) begin
      send_polyline($urandom_range(1, 6), 1 << $urandom_range(4, 17));
      drain_results();
    end
  endtask

  task automatic test_random_polylines(input int unsigned target);
    segment_t sg;
    while (segments_sent < target) begin
      sender_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          sg = segment_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
          sg.last_segment = ($urandom_range(0, 3) == 0);
          send_segment(sg);
        end
      end else if ($urandom_range(0, 9) == 0) begin
        send_polyline($urandom_range(9, 16), 1 << $urandom_range(1, 17));
      end else begin
        send_polyline($urandom_range(1, 8), 1 << $urandom_range(1, 17));
      end
    end
    sender_steady = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (ready_run == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b1;
        ready_run = 300;
      end else if ($urandom_range(0, 2) != 0) begin
        m_axis_tready_i <= 1'b1;
        ready_run = $urandom_range(1, 40);
      end else begin
        m_axis_tready_i <= 1'b0;
        ready_run = $urandom_range(1, 20);
      end
    end else begin
      ready_run--;
    end
  end

  always @(posedge clk_i) begin : check_result
    polyline_result_t   want;
    logic [DistSqW-1:0] got_sq;
    logic [DistW-1:0]   got_root;
    got_sq = m_axis_tdata_o[DistSqW-1:0];
    got_root = m_axis_tdata_o[DistSqW +: DistW];
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_minima.size() == 0) begin
        $error("min_dist_sq: no result expected, actual %0d", got_sq);
        mismatches++;
      end else begin
        want = pending_minima.pop_front();
        if (got_sq !== want.min_dist_sq) begin
          $error("min_dist_sq: expected %0d, actual %0d", want.min_dist_sq, got_sq);
          mismatches++;
        end
        if (got_root !== want.min_dist) begin
          $error("min_dist: expected %0d, actual %0d", want.min_dist, got_root);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("point_polyline_min_distance test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_drain_pause();
    test_random_polylines(1020);
    test_drain_pause();
    drain_results();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("point_polyline_min_distance test passed");
    end else begin
      $display("point_polyline_min_distance test failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ppmd_pkg.sv
hw/rtl/ppmd_mac.sv
hw/rtl/ppmd_div.sv
hw/rtl/ppmd_sqrt.sv
hw/rtl/point_polyline_min_distance.sv
sim/tb_point_polyline_min_distance.sv
